// File: sv/fsqrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsqrt_pkg
// Shared constants and the pipeline stage record of the square root core.
// ----------------------------------------------------------------------------
package fsqrt_pkg;

  localparam int unsigned NewtonSteps     = 3;
  localparam int unsigned DivBitsPerStage = 5;
  localparam int unsigned DivStages       = 5;
  // divider stages, quotient rounding, alignment add, normalize and halve
  localparam int unsigned StagesPerStep   = DivStages + 3;
  // decode, Newton steps, multiply, round and pack
  localparam int unsigned NumStages       = 1 + StagesPerStep * NewtonSteps + 2;

  localparam logic [23:0]       OneSig   = 24'h800000;
  localparam logic [23:0]       Root2Sig = 24'hB504F3;
  // 0.5 * (1 + sqrt2) rounded in single precision
  localparam logic [23:0]       GuessSig = 24'h9A827A;
  localparam logic signed [9:0] ExpBias  = 10'sd127;

  typedef struct packed {
    logic [23:0]       m_sig;
    logic [23:0]       g_sig;
    logic signed [9:0] g_exp;
    logic [25:0]       rem;
    logic [24:0]       quo;
    logic signed [9:0] q_exp;
    logic [23:0]       q_sig;
    logic [50:0]       sum;
    logic signed [9:0] sum_exp;
    logic              sum_stk;
    logic [47:0]       prod;
    logic signed [9:0] prod_exp;
    logic signed [9:0] half_exp;
    logic              odd;
    logic              neg;
    logic [31:0]       root;
  } stage_t;

endpackage

// File: sv/float_sqrt_newton_core.sv
`timescale 1ns / 1ps
// Throughput: one operand per cycle unless the output stalls.
// Each Newton step is a 5-stage radix-2 divider,
// a quotient rounding stage, an alignment add stage and a normalize stage.
// A stall on the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears the stage valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
// float_sqrt_newton_core
// Pipelined single-precision square root by Newton iteration with per-operation
// round-to-nearest-even, followed by exponent halving and sqrt2 correction.
// ----------------------------------------------------------------------------
module float_sqrt_newton_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] operand_bits
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [31:0] root_bits
);

  localparam int unsigned Last = fsqrt_pkg::NumStages - 1;

  fsqrt_pkg::stage_t                  stage_d [fsqrt_pkg::NumStages];
  fsqrt_pkg::stage_t                  stage_q [fsqrt_pkg::NumStages];
  logic [fsqrt_pkg::NumStages-1:0]    valid_q;
  logic                               adv;

  function automatic fsqrt_pkg::stage_t init_div(fsqrt_pkg::stage_t d);
    fsqrt_pkg::stage_t r;
    r = d;
    // keep the first partial remainder in [G, 2G)
    if (d.m_sig >= d.g_sig) begin
      r.rem   = {2'b00, d.m_sig};
      r.q_exp = -d.g_exp;
    end else begin
      r.rem   = {1'b0, d.m_sig, 1'b0};
      r.q_exp = -d.g_exp - 10'sd1;
    end
    r.quo = '0;
    return r;
  endfunction

  function automatic fsqrt_pkg::stage_t decode(logic [31:0] x);
    fsqrt_pkg::stage_t r;
    logic signed [9:0] e;
    r          = '0;
    e          = $signed({2'b00, x[30:23]}) - fsqrt_pkg::ExpBias;
    // halve toward zero
    r.half_exp = (e + $signed({9'd0, e[9]})) >>> 1;
    r.odd      = e[0];
    r.neg      = e[9];
    r.m_sig    = {1'b1, x[22:0]};
    r.g_sig    = fsqrt_pkg::GuessSig;
    r.g_exp    = '0;
    return init_div(r);
  endfunction

  function automatic fsqrt_pkg::stage_t div_step(fsqrt_pkg::stage_t d);
    fsqrt_pkg::stage_t r;
    logic [25:0] gx;
    r  = d;
    gx = {2'b00, d.g_sig};
    for (int i = 0; i < fsqrt_pkg::DivBitsPerStage; i++) begin
      if (r.rem >= gx) begin
        r.rem = r.rem - gx;
        r.quo = {r.quo[23:0], 1'b1};
      end else begin
        r.quo = {r.quo[23:0], 1'b0};
      end
      r.rem = {r.rem[24:0], 1'b0};
    end
    return r;
  endfunction

  function automatic fsqrt_pkg::stage_t round_quo(fsqrt_pkg::stage_t d);
    fsqrt_pkg::stage_t r;
    logic [24:0] sig;
    logic        up;
    r   = d;
    up  = d.quo[0] & ((d.rem != '0) | d.quo[1]);
    sig = {1'b0, d.quo[24:1]} + {24'd0, up};
    if (sig[24]) begin
      r.q_sig = fsqrt_pkg::OneSig;
      r.q_exp = d.q_exp + 10'sd1;
    end else begin
      r.q_sig = sig[23:0];
    end
    return r;
  endfunction

  function automatic fsqrt_pkg::stage_t add_align(fsqrt_pkg::stage_t d);
    fsqrt_pkg::stage_t r;
    logic [23:0]       big_sig;
    logic [23:0]       sml_sig;
    logic signed [9:0] big_exp;
    logic signed [9:0] diff;
    logic [5:0]        dc;
    logic [99:0]       wide;
    r = d;
    if (d.q_exp >= d.g_exp) begin
      big_sig = d.q_sig;
      big_exp = d.q_exp;
      sml_sig = d.g_sig;
      diff    = d.q_exp - d.g_exp;
    end else begin
      big_sig = d.g_sig;
      big_exp = d.g_exp;
      sml_sig = d.q_sig;
      diff    = d.g_exp - d.q_exp;
    end
    dc        = (diff > 10'sd50) ? 6'd50 : diff[5:0];
    wide      = {sml_sig, 76'd0} >> dc;
    r.sum     = {1'b0, big_sig, 26'd0} + {1'b0, wide[99:50]};
    r.sum_exp = big_exp;
    r.sum_stk = |wide[49:0];
    return r;
  endfunction

  function automatic fsqrt_pkg::stage_t norm_sum(fsqrt_pkg::stage_t d);
    fsqrt_pkg::stage_t r;
    logic [23:0]       sig;
    logic [24:0]       s25;
    logic              rb;
    logic              st;
    logic signed [9:0] ex;
    r = d;
    if (d.sum[50]) begin
      sig = d.sum[50:27];
      rb  = d.sum[26];
      st  = (|d.sum[25:0]) | d.sum_stk;
      ex  = d.sum_exp + 10'sd1;
    end else begin
      sig = d.sum[49:26];
      rb  = d.sum[25];
      st  = (|d.sum[24:0]) | d.sum_stk;
      ex  = d.sum_exp;
    end
    s25 = {1'b0, sig} + {24'd0, rb & (st | sig[0])};
    if (s25[24]) begin
      r.g_sig = fsqrt_pkg::OneSig;
      ex      = ex + 10'sd1;
    end else begin
      r.g_sig = s25[23:0];
    end
    // times one half
    r.g_exp = ex - 10'sd1;
    return init_div(r);
  endfunction

  function automatic fsqrt_pkg::stage_t mult(fsqrt_pkg::stage_t d);
    fsqrt_pkg::stage_t r;
    logic [23:0] c_sig;
    r          = d;
    c_sig      = d.odd ? fsqrt_pkg::Root2Sig : fsqrt_pkg::OneSig;
    r.prod     = {24'd0, c_sig} * {24'd0, d.g_sig};
    r.prod_exp = (d.odd && d.neg) ? (d.g_exp - 10'sd1) : d.g_exp;
    return r;
  endfunction

  function automatic fsqrt_pkg::stage_t pack(fsqrt_pkg::stage_t d);
    fsqrt_pkg::stage_t r;
    logic [23:0]       sig;
    logic [24:0]       s25;
    logic              rb;
    logic              st;
    logic signed [9:0] ex;
    r  = d;
    ex = d.prod_exp + d.half_exp + fsqrt_pkg::ExpBias;
    if (d.prod[47]) begin
      sig = d.prod[47:24];
      rb  = d.prod[23];
      st  = |d.prod[22:0];
      ex  = ex + 10'sd1;
    end else begin
      sig = d.prod[46:23];
      rb  = d.prod[22];
      st  = |d.prod[21:0];
    end
    s25 = {1'b0, sig} + {24'd0, rb & (st | sig[0])};
    if (s25[24]) begin
      sig = fsqrt_pkg::OneSig;
      ex  = ex + 10'sd1;
    end else begin
      sig = s25[23:0];
    end
    r.root = {1'b0, ex[7:0], sig[22:0]};
    return r;
  endfunction

  // advance the whole pipe unless the output holds a result nobody takes
  assign adv             = m_axis_tready_i || !valid_q[Last];
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = valid_q[Last];
  assign m_axis_tdata_o  = stage_q[Last].root;

  for (genvar s = 0; s < fsqrt_pkg::NumStages; s++) begin : g_stage
    if (s == 0) begin : g_dec
      assign stage_d[s] = decode(s_axis_tdata_i);
    end else if (s == Last - 1) begin : g_mul
      assign stage_d[s] = mult(stage_q[s-1]);
    end else if (s == Last) begin : g_pack
      assign stage_d[s] = pack(stage_q[s-1]);
    end else if ((s - 1) % fsqrt_pkg::StagesPerStep < fsqrt_pkg::DivStages) begin : g_div
      assign stage_d[s] = div_step(stage_q[s-1]);
    end else if ((s - 1) % fsqrt_pkg::StagesPerStep == fsqrt_pkg::DivStages) begin : g_rq
      assign stage_d[s] = round_quo(stage_q[s-1]);
    end else if ((s - 1) % fsqrt_pkg::StagesPerStep == fsqrt_pkg::DivStages + 1) begin : g_add
      assign stage_d[s] = add_align(stage_q[s-1]);
    end else begin : g_norm
      assign stage_d[s] = norm_sum(stage_q[s-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[Last-1:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stage_q <= stage_d;
    end
  end

  // the root is never negative
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[31])
    else $error("sign bit set on root");

  // a frozen pipe keeps every valid bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(valid_q))
    else $error("valid bits moved during stall");

  for (genvar k = 0; k < fsqrt_pkg::NewtonSteps; k++) begin : g_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid_q[fsqrt_pkg::StagesPerStep*(k+1)] |->
        stage_q[fsqrt_pkg::StagesPerStep*(k+1)].g_sig[23])
      else $error("estimate not normalized after Newton step");
  end

endmodule
